### rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    localparam int LENGTH_BITS_DEF   = 12;
    localparam int POSITION_BITS_DEF = 16;

    // result queue between the scanner and the output port
    localparam int QUEUE_DEPTH = 4;

    localparam int KIND_BITS   = 4;
    localparam int PREFIX_BITS = 48;
    localparam int NUM_KW      = 8;

    localparam logic [KIND_BITS-1:0] KIND_NAME    = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_INT     = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_STAR    = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_OPEN    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_CLOSE   = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_GREATER = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_SELECT  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_ERROR   = 4'd15;

    localparam logic [7:0] CHAR_STAR    = 8'h2a;
    localparam logic [7:0] CHAR_COMMA   = 8'h2c;
    localparam logic [7:0] CHAR_OPEN    = 8'h28;
    localparam logic [7:0] CHAR_CLOSE   = 8'h29;
    localparam logic [7:0] CHAR_GREATER = 8'h3e;

    // first character sits in the top byte, unused bytes are zero
    localparam logic [PREFIX_BITS-1:0] KW_TEXT [NUM_KW] = '{
        48'("select"),
        {32'("from"), 16'h0000},
        48'("insert"),
        {32'("into"), 16'h0000},
        48'("values"),
        48'("create"),
        {40'("table"), 8'h00},
        {40'("where"), 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd6, 3'd4, 3'd6, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5
    };

    typedef struct packed {
        logic first;
        logic second;
    } sts_push_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'd65) && (c <= 8'd90);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

`default_nettype wire

### rtl/sts_step.sv
`default_nettype none

module sts_step
    import sts_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     fire,
    input  wire logic [7:0]               character,
    input  wire logic                     end_of_input,
    output sts_push_t                     push,
    output logic      [KIND_BITS-1:0]     res0_kind,
    output logic      [LENGTH_BITS-1:0]   res0_length,
    output logic      [POSITION_BITS-1:0] res0_end_position,
    output logic                          res0_last,
    output logic      [KIND_BITS-1:0]     res1_kind,
    output logic      [LENGTH_BITS-1:0]   res1_length,
    output logic      [POSITION_BITS-1:0] res1_end_position
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NAME = 2'd1,
        MODE_INT  = 2'd2
    } mode_t;

    mode_t                    mode_reg,   mode_next;
    logic [LENGTH_BITS-1:0]   len_reg,    len_next;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [KIND_BITS-1:0]     name_kind;
    logic [KIND_BITS-1:0]     flush_kind;
    logic [KIND_BITS-1:0]     mark_kind;
    logic                     pending;
    logic                     grows;
    logic                     c_blank, c_letter, c_digit;

    assign pos_inc  = pos_reg + 1'b1;
    assign pending  = (mode_reg == MODE_NAME) || (mode_reg == MODE_INT);
    assign c_blank  = is_blank(character);
    assign c_letter = is_letter(character);
    assign c_digit  = is_digit(character);
    assign grows    = ((mode_reg == MODE_NAME) && (c_letter || c_digit)) ||
                      ((mode_reg == MODE_INT) && c_digit);

    // keyword lengths never reach the saturated length, so no extra check
    always_comb begin
        name_kind = KIND_NAME;
        for (int i = 0; i < NUM_KW; i++) begin
            if ((len_reg == LENGTH_BITS'(KW_LEN[i])) && (prefix_reg == KW_TEXT[i])) begin
                name_kind = KIND_SELECT + KIND_BITS'(i);
            end
        end
    end

    assign flush_kind = (mode_reg == MODE_NAME) ? name_kind : KIND_INT;

    always_comb begin
        unique case (character)
            CHAR_STAR:    mark_kind = KIND_STAR;
            CHAR_COMMA:   mark_kind = KIND_COMMA;
            CHAR_OPEN:    mark_kind = KIND_OPEN;
            CHAR_CLOSE:   mark_kind = KIND_CLOSE;
            CHAR_GREATER: mark_kind = KIND_GREATER;
            default:      mark_kind = KIND_ERROR;
        endcase
    end

    always_comb begin
        logic flush;
        logic mark;

        mode_next   = mode_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        pos_next    = pos_reg;
        flush       = 1'b0;
        mark        = 1'b0;

        if (end_of_input) begin
            flush       = pending;
            mode_next   = MODE_IDLE;
            len_next    = '0;
            prefix_next = '0;
            pos_next    = '0;
        end else begin
            pos_next = pos_inc;
            if (grows) begin
                if (len_reg != {LENGTH_BITS{1'b1}}) begin
                    len_next = len_reg + 1'b1;
                end
                if (mode_reg == MODE_NAME) begin
                    for (int j = 0; j < 6; j++) begin
                        if (len_reg == LENGTH_BITS'(j)) begin
                            prefix_next[PREFIX_BITS-1-8*j -: 8] = to_lower(character);
                        end
                    end
                end
            end else begin
                // ending byte is looked at again as if between tokens
                flush       = pending;
                mode_next   = MODE_IDLE;
                len_next    = '0;
                prefix_next = '0;
                if (c_letter) begin
                    mode_next = MODE_NAME;
                    len_next  = LENGTH_BITS'(1);
                    prefix_next[PREFIX_BITS-1 -: 8] = to_lower(character);
                end else if (c_digit) begin
                    mode_next = MODE_INT;
                    len_next  = LENGTH_BITS'(1);
                end else if (!c_blank) begin
                    mark = 1'b1;
                end
            end
        end

        push.first        = flush || mark;
        push.second       = flush && mark;
        res0_kind         = flush ? flush_kind : mark_kind;
        res0_length       = flush ? len_reg : LENGTH_BITS'(1);
        res0_end_position = flush ? pos_reg : pos_inc;
        res0_last         = !(flush && mark);
        res1_kind         = mark_kind;
        res1_length       = LENGTH_BITS'(1);
        res1_end_position = pos_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            prefix_reg <= '0;
            pos_reg    <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sts_result_queue.sv
`default_nettype none

module sts_result_queue
    import sts_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sts_push_t        push,
    input  wire logic [WIDTH-1:0] wr0_data,
    input  wire logic [WIDTH-1:0] wr1_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  rd_valid,
    output logic                  room_two
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = rd_en && rd_valid;
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = entry_reg[rd_ptr_reg];
    assign room_two     = (count_reg <= (PTR_W+1)'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.first) + PTR_W'(push.second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.first) + (PTR_W+1)'(push.second)
                      - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.first) begin
            entry_reg[wr_ptr_reg] <= wr0_data;
        end
        if (push.second) begin
            entry_reg[wr_ptr_plus1] <= wr1_data;
        end
    end

endmodule

`default_nettype wire

### rtl/sql_token_scanner.sv
`default_nettype none

// channel  ports                                       direction
// s_       s_valid s_ready s_character s_end_of_input  character words in
// m_       m_valid m_ready m_token_kind m_token_length
//          m_token_end_position m_last_result          token words out
//
// a character word is registered on accept and scanned from that register;
// the scan writes zero, one or two token words into a four-entry queue
// one character per cycle while each character gives at most one token and the output takes its words;
// a character that gives two tokens puts two token words out at the output port
// scanning waits while the queue has fewer than two free entries
// synchronous active-low reset returns to between tokens at position zero

module sql_token_scanner
    import sts_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_character,
    input  wire logic                     s_end_of_input,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [KIND_BITS-1:0]     m_token_kind,
    output logic      [LENGTH_BITS-1:0]   m_token_length,
    output logic      [POSITION_BITS-1:0] m_token_end_position,
    output logic                          m_last_result
);

    localparam int RES_W = KIND_BITS + LENGTH_BITS + POSITION_BITS + 1;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       eoi_reg;
    logic       fire;
    logic       room_two;

    sts_push_t                push, push_fire;
    logic [KIND_BITS-1:0]     res0_kind,   res1_kind;
    logic [LENGTH_BITS-1:0]   res0_length, res1_length;
    logic [POSITION_BITS-1:0] res0_end,    res1_end;
    logic                     res0_last;
    logic [RES_W-1:0]         wr0_data, wr1_data, rd_data;

    assign fire    = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_character;
            eoi_reg  <= s_end_of_input;
        end
    end

    sts_step #(
        .LENGTH_BITS   (LENGTH_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fire              (fire),
        .character         (char_reg),
        .end_of_input      (eoi_reg),
        .push              (push),
        .res0_kind         (res0_kind),
        .res0_length       (res0_length),
        .res0_end_position (res0_end),
        .res0_last         (res0_last),
        .res1_kind         (res1_kind),
        .res1_length       (res1_length),
        .res1_end_position (res1_end)
    );

    // second token word is always the last of its character
    assign wr0_data = {res0_kind, res0_length, res0_end, res0_last};
    assign wr1_data = {res1_kind, res1_length, res1_end, 1'b1};

    always_comb begin
        push_fire.first  = push.first && fire;
        push_fire.second = push.second && fire;
    end

    sts_result_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_fire),
        .wr0_data (wr0_data),
        .wr1_data (wr1_data),
        .rd_en    (m_ready),
        .rd_data  (rd_data),
        .rd_valid (m_valid),
        .room_two (room_two)
    );

    assign {m_token_kind, m_token_length, m_token_end_position, m_last_result} = rd_data;

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
    import sts_pkg::*;

    localparam int LEN_W        = LENGTH_BITS_DEF;
    localparam int POS_W        = POSITION_BITS_DEF;
    localparam int RANDOM_WORDS = 1200;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NAME, SCAN_INT} scan_mode_t;
    typedef enum logic [1:0] {CH_BLANK, CH_LETTER, CH_DIGIT, CH_OTHER} char_class_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [LEN_W-1:0]     length;
        logic [POS_W-1:0]     end_pos;
        logic                 last;
    } token_word_t;

    function automatic char_class_t classify(input logic [7:0] c);
        logic [7:0] folded = c | 8'h20;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))
            return CH_BLANK;
        if (folded >= "a" && folded <= "z")
            return CH_LETTER;
        if (c >= "0" && c <= "9")
            return CH_DIGIT;
        return CH_OTHER;
    endfunction

    function automatic logic [KIND_BITS-1:0] mark_kind(input logic [7:0] c);
        case (c)
            CHAR_STAR:    return KIND_STAR;
            CHAR_COMMA:   return KIND_COMMA;
            CHAR_OPEN:    return KIND_OPEN;
            CHAR_CLOSE:   return KIND_CLOSE;
            CHAR_GREATER: return KIND_GREATER;
            default:      return KIND_ERROR;
        endcase
    endfunction

    class token_scoreboard;
        scan_mode_t       mode;
        logic [LEN_W-1:0] run_len;
        logic [7:0]       prefix [6];
        logic [POS_W-1:0] pos;
        token_word_t      tokens_due [$];
        int               mismatches;
        string            keywords [8];

        function new();
            keywords = '{"select", "from", "insert", "into",
                         "values", "create", "table", "where"};
            mode = SCAN_IDLE;
            pos = '0;
            mismatches = 0;
            clear_token();
        endfunction

        function void clear_token();
            run_len = '0;
            foreach (prefix[i])
                prefix[i] = 8'h00;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function logic [KIND_BITS-1:0] name_kind();
            bit hit;
            // a saturated length never matches a keyword
            if (run_len == '1)
                return KIND_NAME;
            for (int k = 0; k < 8; k++) begin
                if (run_len == keywords[k].len()) begin
                    hit = 1'b1;
                    for (int j = 0; j < keywords[k].len(); j++)
                        if (prefix[j] != keywords[k][j])
                            hit = 1'b0;
                    if (hit)
                        return KIND_SELECT + KIND_BITS'(k);
                end
            end
            return KIND_NAME;
        endfunction

        function void emit(input logic [KIND_BITS-1:0] kind, input logic [LEN_W-1:0] len,
                           input logic [POS_W-1:0] end_pos);
            token_word_t w;
            w.kind = kind;
            w.length = len;
            w.end_pos = end_pos;
            w.last = 1'b0;
            tokens_due.insert(tokens_due.size(), w);
        endfunction

        function void flush(input logic [POS_W-1:0] end_pos);
            emit(mode == SCAN_NAME ? name_kind() : KIND_INT, run_len, end_pos);
            mode = SCAN_IDLE;
            clear_token();
        endfunction

        function void grow(input logic [7:0] c);
            if (mode == SCAN_NAME && run_len < 6)
                prefix[run_len] = (classify(c) == CH_LETTER) ? (c | 8'h20) : c;
            if (run_len != '1)
                run_len++;
        endfunction

        // character seen with no token open; pos already counts it
        function void between_tokens(input logic [7:0] c);
            case (classify(c))
                CH_BLANK: ;
                CH_LETTER: begin
                    clear_token();
                    mode = SCAN_NAME;
                    run_len = LEN_W'(1);
                    prefix[0] = c | 8'h20;
                end
                CH_DIGIT: begin
                    clear_token();
                    mode = SCAN_INT;
                    run_len = LEN_W'(1);
                end
                default: emit(mark_kind(c), LEN_W'(1), pos);
            endcase
        endfunction

        function void take_char(input logic [7:0] c, input logic eoi);
            logic [POS_W-1:0] old_pos = pos;
            int first = tokens_due.size();
            char_class_t cls = classify(c);
            if (eoi) begin
                if (mode != SCAN_IDLE)
                    flush(old_pos);
                mode = SCAN_IDLE;
                clear_token();
                pos = '0;
            end else begin
                pos = pos + 1'b1;
                case (mode)
                    SCAN_NAME:
                        if (cls == CH_LETTER || cls == CH_DIGIT) begin
                            grow(c);
                        end else begin
                            flush(old_pos);
                            between_tokens(c);
                        end
                    SCAN_INT:
                        if (cls == CH_DIGIT) begin
                            grow(c);
                        end else begin
                            flush(old_pos);
                            between_tokens(c);
                        end
                    default: between_tokens(c);
                endcase
            end
            if (tokens_due.size() > first)
                tokens_due[tokens_due.size() - 1].last = 1'b1;
        endfunction

        function void check_token(input token_word_t got);
            token_word_t want;
            if (tokens_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token word: kind %0d length %0d end %0d last %0d",
                             got.kind, got.length, got.end_pos, got.last);
                return;
            end
            want = tokens_due.pop_front();
            if (got.kind !== want.kind || got.length !== want.length ||
                got.end_pos !== want.end_pos || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"token word mismatch: kind %0d/%0d length %0d/%0d ",
                              "end %0d/%0d last %0d/%0d (got/exp)"},
                             got.kind, want.kind, got.length, want.length,
                             got.end_pos, want.end_pos, got.last, want.last);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_character;
    logic                 s_end_of_input;
    logic                 m_valid;
    logic                 m_ready;
    logic [KIND_BITS-1:0] m_token_kind;
    logic [LEN_W-1:0]     m_token_length;
    logic [POS_W-1:0]     m_token_end_position;
    logic                 m_last_result;

    token_scoreboard sb;
    bit              no_idle;
    int              words_sent;

    sql_token_scanner DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_character          (s_character),
        .s_end_of_input       (s_end_of_input),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_token_kind         (m_token_kind),
        .m_token_length       (m_token_length),
        .m_token_end_position (m_token_end_position),
        .m_last_result        (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
    endfunction

    function automatic logic [7:0] pick_blank();
        int r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'h08 + 8'(r);
    endfunction

    function automatic logic [7:0] pick_mark();
        case ($urandom_range(0, 4))
            0:       return CHAR_STAR;
            1:       return CHAR_COMMA;
            2:       return CHAR_OPEN;
            3:       return CHAR_CLOSE;
            default: return CHAR_GREATER;
        endcase
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eoi);
        int gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_character <= c;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.take_char(c, eoi);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // a run of tokens with random spacing, optionally closed by end of input
    task automatic send_query(input bit finish);
        logic [7:0] text [$];
        string kw;
        int n;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    kw = sb.keywords[$urandom_range(0, 7)];
                    n = kw.len();
                    // near misses: one short or one long
                    if ($urandom_range(0, 5) == 0)
                        n--;
                    for (int j = 0; j < n; j++)
                        text.insert(text.size(),
                                    ($urandom_range(0, 2) == 0) ? (kw[j] ^ 8'h20) : kw[j]);
                    if ($urandom_range(0, 5) == 0)
                        text.insert(text.size(), pick_alnum());
                end
                3, 4: begin
                    text.insert(text.size(), pick_letter());
                    repeat ($urandom_range(0, 9))
                        text.insert(text.size(), pick_alnum());
                end
                5, 6: begin
                    repeat ($urandom_range(1, 8))
                        text.insert(text.size(), pick_digit());
                end
                7, 8: text.insert(text.size(), pick_mark());
                default: text.insert(text.size(), 8'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 3))
                0: ;
                1, 2: text.insert(text.size(), pick_blank());
                default: begin
                    repeat ($urandom_range(2, 4))
                        text.insert(text.size(), pick_blank());
                end
            endcase
        end
        foreach (text[i])
            send_word(text[i], 1'b0);
        if (finish)
            send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // token word sink
    initial begin
        int stall;
        token_word_t got;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.kind = m_token_kind;
            got.length = m_token_length;
            got.end_pos = m_token_end_position;
            got.last = m_last_result;
            sb.check_token(got);
        end
    end

    initial begin
        int start;
        sb = new();
        no_idle = 1'b0;
        words_sent = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_character <= 8'h00;
        s_end_of_input <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // keyword closed by a mark, integer closed by unknown bytes, every mark,
        // flush at end of input, end of input with nothing open
        send_text("WhErE>70");
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b0);
        send_text("*,()\tx9");
        send_word(8'h5a, 1'b1);
        send_word(8'h00, 1'b1);
        send_word("k", 1'b0);
        send_word(8'hff, 1'b1);
        send_text("42");
        send_word(8'haa, 1'b1);

        start = words_sent;
        while (words_sent < start + RANDOM_WORDS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                send_query($urandom_range(0, 6) != 0);
            end
        end
        no_idle = 1'b0;

        s_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
